>>> src/opsu_pkg.sv
package opsu_pkg;

    // Field and register widths
    localparam int P_ELAPSED_W = 32;
    localparam int P_COORD_W   = 32;
    localparam int P_TRIG_W    = 16;
    localparam int P_RADIUS_W  = 31;
    localparam int P_RATE_W    = 40;
    localparam int P_PHASE_W   = 48;
    localparam int P_IN_W      = P_ELAPSED_W + 3 * P_COORD_W;
    localparam int P_OUT_W     = 3 * P_COORD_W + 2 * P_TRIG_W;

    // Configuration port
    localparam int P_CFG_IDX_W  = 2;
    localparam int P_CFG_DATA_W = P_RATE_W;
    localparam logic [P_CFG_IDX_W-1:0] CFG_ORBIT_ENABLE = 2'd0;
    localparam logic [P_CFG_IDX_W-1:0] CFG_ORBIT_RADIUS = 2'd1;
    localparam logic [P_CFG_IDX_W-1:0] CFG_ORBIT_RATE   = 2'd2;
    localparam logic [P_CFG_IDX_W-1:0] CFG_SPIN_RATE    = 2'd3;

    // CORDIC datapath
    localparam int P_CORDIC_STEPS = 16;
    localparam int P_TABLE_LEN    = 24;
    localparam int P_ITER_W       = $clog2(P_TABLE_LEN);
    localparam int P_CORD_W       = 34;
    localparam logic signed [P_CORD_W-1:0] P_GAIN_Q30    = 34'sd652032874;
    localparam logic signed [P_CORD_W-1:0] P_QUARTER     = 34'sd1073741824;
    localparam logic signed [P_CORD_W-1:0] P_HALF        = 34'sd2147483648;
    localparam logic signed [17:0]         P_TRIG_MAX    = 18'sd16384;
    localparam logic signed [17:0]         P_TRIG_MIN    = -18'sd16384;

    // Arctangent of 2^-i, in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [P_ITER_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/orbit_position_spin_update_top.sv
// Each request runs the phase multiplies, CORDIC and, with the orbit enabled, the position steps in turn.
// Results load once the output register is free; a new request is taken in the cycle after a load.
// No request overlaps another, since one shared 33x33 multiplier and one CORDIC stage are reused, the
// stage once per iteration, CORDIC_STEPS iterations per angle, capped at the 24-entry table length.
// Reset (synchronous, active low) clears both phases, configuration, sequencer and valid flag.
module orbit_position_spin_update_top #(
    parameter int CORDIC_STEPS = opsu_pkg::P_CORDIC_STEPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [opsu_pkg::P_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [opsu_pkg::P_CFG_DATA_W-1:0]   i_cfg_data,
    // Tick requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // elapsed, center_x, center_y, center_z
    input  logic [opsu_pkg::P_IN_W-1:0]         s_axis_tdata,
    // Results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pos_x, pos_y, pos_z, spin_cos, spin_sin
    output logic [opsu_pkg::P_OUT_W-1:0]        m_axis_tdata
);

    localparam int STEPS = (CORDIC_STEPS > opsu_pkg::P_TABLE_LEN) ?
                           opsu_pkg::P_TABLE_LEN : CORDIC_STEPS;
    localparam int IW = opsu_pkg::P_ITER_W;
    localparam int CW = opsu_pkg::P_CORD_W;
    localparam int PW = opsu_pkg::P_PHASE_W;
    localparam int TW = opsu_pkg::P_TRIG_W;
    localparam int XW = opsu_pkg::P_COORD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MLO   = 4'd1;
    localparam logic [3:0] S_MHI   = 4'd2;
    localparam logic [3:0] S_MADD  = 4'd3;
    localparam logic [3:0] S_CINIT = 4'd4;
    localparam logic [3:0] S_CITER = 4'd5;
    localparam logic [3:0] S_CDONE = 4'd6;
    localparam logic [3:0] S_PX    = 4'd7;
    localparam logic [3:0] S_PXA   = 4'd8;
    localparam logic [3:0] S_PZA   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // Configuration registers
    logic                                   r_orbit_enable;
    logic [opsu_pkg::P_RADIUS_W-1:0]        r_orbit_radius;
    logic [opsu_pkg::P_RATE_W-1:0]          r_orbit_rate;
    logic [opsu_pkg::P_RATE_W-1:0]          r_spin_rate;

    // Sequencer and state
    logic [3:0]                             r_state;
    logic [3:0]                             n_state;
    logic                                   r_sel;      // 0: orbit, 1: spin
    logic [PW-1:0]                          r_orbit_phase;
    logic [PW-1:0]                          r_spin_phase;
    logic [PW-1:0]                          r_acc;

    // Latched request
    logic [opsu_pkg::P_ELAPSED_W-1:0]       r_elapsed;
    logic signed [XW-1:0]                   r_cx;
    logic signed [XW-1:0]                   r_cy;
    logic signed [XW-1:0]                   r_cz;

    // Shared multiplier
    logic signed [32:0]                     w_ma;
    logic signed [32:0]                     w_mb;
    logic signed [65:0]                     w_prod;
    logic signed [65:0]                     r_prod;

    // CORDIC registers
    logic signed [CW-1:0]                   r_x;
    logic signed [CW-1:0]                   r_y;
    logic signed [CW-1:0]                   r_z;
    logic [IW-1:0]                          r_iter;
    logic                                   r_flip;

    // Results
    logic signed [TW-1:0]                   r_ocos;
    logic signed [TW-1:0]                   r_osin;
    logic signed [TW-1:0]                   r_scos;
    logic signed [TW-1:0]                   r_ssin;
    logic signed [XW-1:0]                   r_px;
    logic signed [XW-1:0]                   r_pz;
    logic                                   r_m_valid;
    logic [opsu_pkg::P_OUT_W-1:0]           r_m_data;

    // Combinational helpers
    logic [opsu_pkg::P_RATE_W-1:0]          w_rate;
    logic [PW-1:0]                          w_phase;
    logic signed [CW-1:0]                   w_z0;
    logic signed [CW-1:0]                   w_dx;
    logic signed [CW-1:0]                   w_dy;
    logic signed [CW-1:0]                   w_atan;
    logic signed [17:0]                     w_rc;
    logic signed [17:0]                     w_rs;
    logic signed [TW-1:0]                   w_qc;
    logic signed [TW-1:0]                   w_qs;
    logic signed [33:0]                     w_off;
    logic signed [34:0]                     w_sum;
    logic signed [XW-1:0]                   w_sat;
    logic signed [XW-1:0]                   w_ctr;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Operands of the selected accumulator
    assign w_rate  = r_sel ? r_spin_rate : r_orbit_rate;
    assign w_phase = r_sel ? r_spin_phase : r_orbit_phase;

    // Multiplier operand selection by step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MLO: begin
                w_ma = $signed({1'b0, w_rate[31:0]});
                w_mb = $signed({1'b0, r_elapsed});
            end
            S_MHI: begin
                w_ma = $signed({25'd0, w_rate[opsu_pkg::P_RATE_W-1:32]});
                w_mb = $signed({1'b0, r_elapsed});
            end
            S_PX: begin
                w_ma = $signed({2'b0, r_orbit_radius});
                w_mb = 33'(r_ocos);
            end
            S_PXA: begin
                w_ma = $signed({2'b0, r_orbit_radius});
                w_mb = 33'(r_osin);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Angle from the top 32 phase bits, sign-extended; it is folded into the right half plane at CORDIC init
    assign w_z0 = CW'($signed(w_phase[PW-1:PW-32]));

    // One CORDIC rotation
    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = $signed({{(CW-32){1'b0}}, opsu_pkg::atan_turn(r_iter)});

    // Q30 to Q14, rounding half up, clamping to plus or minus one, then negating for a folded angle
    assign w_rc = 18'((r_x + 34'sd32768) >>> 16);
    assign w_rs = 18'((r_y + 34'sd32768) >>> 16);
    always_comb begin
        if (w_rc > opsu_pkg::P_TRIG_MAX) begin
            w_qc = TW'(opsu_pkg::P_TRIG_MAX);
        end else if (w_rc < opsu_pkg::P_TRIG_MIN) begin
            w_qc = TW'(opsu_pkg::P_TRIG_MIN);
        end else begin
            w_qc = TW'(w_rc);
        end
        if (w_rs > opsu_pkg::P_TRIG_MAX) begin
            w_qs = TW'(opsu_pkg::P_TRIG_MAX);
        end else if (w_rs < opsu_pkg::P_TRIG_MIN) begin
            w_qs = TW'(opsu_pkg::P_TRIG_MIN);
        end else begin
            w_qs = TW'(w_rs);
        end
        if (r_flip) begin
            w_qc = -w_qc;
            w_qs = -w_qs;
        end
    end

    // Offset rounding and saturating add to the centre
    assign w_ctr = (r_state == S_PXA) ? r_cx : r_cz;
    assign w_off = 34'((r_prod + 66'sd8192) >>> 14);
    assign w_sum = 35'(w_ctr) + 35'(w_off);
    always_comb begin
        if (w_sum > 35'sd2147483647) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_sum < -35'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = XW'(w_sum);
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_MADD;
            S_MADD:  n_state = r_sel ? S_CINIT : S_MLO;
            S_CINIT: n_state = S_CITER;
            S_CITER: if (r_iter == IW'(STEPS - 1)) n_state = S_CDONE;
            S_CDONE: begin
                if (!r_sel) begin
                    n_state = S_CINIT;
                end else if (r_orbit_enable) begin
                    n_state = S_PX;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PX:    n_state = S_PXA;
            S_PXA:   n_state = S_PZA;
            S_PZA:   n_state = S_OUT;
            S_OUT:   if (!r_m_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, configuration and phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sel          <= 1'b0;
            r_orbit_enable <= 1'b0;
            r_orbit_radius <= '0;
            r_orbit_rate   <= '0;
            r_spin_rate    <= '0;
            r_orbit_phase  <= '0;
            r_spin_phase   <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    opsu_pkg::CFG_ORBIT_ENABLE: r_orbit_enable <= i_cfg_data[0];
                    opsu_pkg::CFG_ORBIT_RADIUS:
                        r_orbit_radius <= i_cfg_data[opsu_pkg::P_RADIUS_W-1:0];
                    opsu_pkg::CFG_ORBIT_RATE:   r_orbit_rate <= i_cfg_data;
                    opsu_pkg::CFG_SPIN_RATE:    r_spin_rate  <= i_cfg_data;
                    default: ;
                endcase
            end
            // Orbit accumulator runs first only when the orbit is enabled
            if (r_state == S_IDLE && s_axis_tvalid) begin
                r_sel <= !r_orbit_enable;
            end
            if (r_state == S_MADD) begin
                if (r_sel) begin
                    r_spin_phase <= r_acc + {r_prod[31:0], 16'd0};
                    r_sel        <= !r_orbit_enable;
                end else begin
                    r_orbit_phase <= r_acc + {r_prod[31:0], 16'd0};
                    r_sel         <= 1'b1;
                end
            end
            if (r_state == S_CDONE && !r_sel) begin
                r_sel <= 1'b1;
            end
            // Output register, held until the result is taken
            if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_elapsed <= s_axis_tdata[31:0];
            r_cx      <= s_axis_tdata[63:32];
            r_cy      <= s_axis_tdata[95:64];
            r_cz      <= s_axis_tdata[127:96];
        end
        if (r_state == S_MLO || r_state == S_PX || r_state == S_PXA || r_state == S_MHI) begin
            r_prod <= w_prod;
        end
        if (r_state == S_MHI) begin
            r_acc <= w_phase + r_prod[63:16];
        end
        if (r_state == S_CINIT) begin
            r_x    <= opsu_pkg::P_GAIN_Q30;
            r_y    <= '0;
            r_iter <= '0;
            if (w_z0 > opsu_pkg::P_QUARTER) begin
                r_z    <= w_z0 - opsu_pkg::P_HALF;
                r_flip <= 1'b1;
            end else if (w_z0 < -opsu_pkg::P_QUARTER) begin
                r_z    <= w_z0 + opsu_pkg::P_HALF;
                r_flip <= 1'b1;
            end else begin
                r_z    <= w_z0;
                r_flip <= 1'b0;
            end
        end
        if (r_state == S_CITER) begin
            r_iter <= r_iter + 1'b1;
            if (!r_z[CW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
        if (r_state == S_CDONE) begin
            if (r_sel) begin
                r_scos <= w_qc;
                r_ssin <= w_qs;
            end else begin
                r_ocos <= w_qc;
                r_osin <= w_qs;
            end
        end
        if (r_state == S_PXA) begin
            r_px <= w_sat;
        end
        if (r_state == S_PZA) begin
            r_pz <= w_sat;
        end
        if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= {r_ssin, r_scos, r_orbit_enable ? r_pz : r_cz, r_cy,
                         r_orbit_enable ? r_px : r_cx};
        end
    end

    // A new request is never taken in the cycle after one was accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // The CORDIC counter stays inside the configured step count.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CITER) |-> (r_iter < IW'(STEPS)))
        else $error("CORDIC iteration count overran");

    // A result only appears out of the output step.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

    // Reported spin cosine and sine lie within plus or minus one.
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> ($signed(r_m_data[111:96]) <= 16'sd16384 &&
                       $signed(r_m_data[111:96]) >= -16'sd16384 &&
                       $signed(r_m_data[127:112]) <= 16'sd16384 &&
                       $signed(r_m_data[127:112]) >= -16'sd16384))
        else $error("spin trig result out of range");

endmodule
